// ----- rtl/rmfh_pkg.sv -----
// rmfh_pkg: status codes and control state type for the recursive mutex unit
// no dependencies; imported by the top level and the port checker
package rmfh_pkg;

  typedef logic [2:0] status_t;

  localparam status_t ST_ACQUIRED   = 3'd0;
  localparam status_t ST_RECURSED   = 3'd1;
  localparam status_t ST_QUEUED     = 3'd2;
  localparam status_t ST_FULL       = 3'd3;
  localparam status_t ST_SATURATED  = 3'd4;
  localparam status_t ST_NOT_OWNER  = 3'd5;
  localparam status_t ST_STILL_HELD = 3'd6;
  localparam status_t ST_RELEASED   = 3'd7;

  localparam logic CMD_LOCK   = 1'b0;
  localparam logic CMD_UNLOCK = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

endpackage

// ----- rtl/recursive_mutex_fifo_handoff_top.sv -----
// recursive_mutex_fifo_handoff_top: recursive mutex with fifo wait queue and handoff
// depends on rmfh_pkg; waiter queue held in an internal synchronous memory
//
//   channel | ports                                  | handshake
//   --------+----------------------------------------+-------------------------------
//   input   | in_command, in_task_id                 | start high, busy low at edge
//   result  | out_status, out_woken_valid,           | out_valid high for one cycle
//           | out_woken_task, out_depth_after        |
//
// a transaction passes the idle and exec states: on accept the command, task id
// and the queue head read from the waiter memory are registered; in exec the unit
// decides, updates the lock registers, writes the tail entry on a queued lock and
// registers the result. out_valid is high in the cycle after exec; busy is low and
// a new transaction can start. rst_n is synchronous; no stall on the result channel.
module recursive_mutex_fifo_handoff_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int MAX_DEPTH   = 255
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_command,
  input  logic [7:0]           in_task_id,
  output logic                 out_valid,
  output rmfh_pkg::status_t    out_status,
  output logic                 out_woken_valid,
  output logic [7:0]           out_woken_task,
  output logic [7:0]           out_depth_after
);
  import rmfh_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [7:0]       DEPTH_MAX = 8'(MAX_DEPTH);

  logic [7:0] waiter_mem [QUEUE_DEPTH];

  state_t           state_r, state_nxt;
  logic             held_r, held_nxt;
  logic [7:0]       owner_r, owner_nxt;
  logic [7:0]       depth_r, depth_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic             cmd_r;
  logic [7:0]       task_r;
  logic [7:0]       head_data_r;

  logic             out_valid_r;
  status_t          status_r, status_nxt;
  logic             woken_valid_r, woken_valid_nxt;
  logic [7:0]       woken_task_r, woken_task_nxt;
  logic [7:0]       depth_out_r;

  logic             accept;
  logic             is_owner;
  logic             wr_en;

  assign accept   = start && (state_r == S_IDLE);
  assign is_owner = held_r && (owner_r == task_r);

  always_comb begin
    state_nxt       = state_r;
    held_nxt        = held_r;
    owner_nxt       = owner_r;
    depth_nxt       = depth_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    count_nxt       = count_r;
    status_nxt      = ST_NOT_OWNER;
    woken_valid_nxt = 1'b0;
    woken_task_nxt  = 8'd0;
    wr_en           = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        if (cmd_r == CMD_LOCK) begin
          if (is_owner) begin
            if (depth_r >= DEPTH_MAX) begin
              status_nxt = ST_SATURATED;
            end else begin
              depth_nxt  = depth_r + 8'd1;
              status_nxt = ST_RECURSED;
            end
          end else if (!held_r) begin
            held_nxt   = 1'b1;
            owner_nxt  = task_r;
            depth_nxt  = 8'd1;
            status_nxt = ST_ACQUIRED;
          end else if (count_r >= CNT_FULL) begin
            status_nxt = ST_FULL;
          end else begin
            wr_en      = 1'b1;
            tail_nxt   = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
            count_nxt  = count_r + 1'b1;
            status_nxt = ST_QUEUED;
          end
        end else if (is_owner) begin
          depth_nxt = depth_r - 8'd1;
          if (depth_r > 8'd1) begin
            status_nxt = ST_STILL_HELD;
          end else if (count_r != '0) begin
            head_nxt        = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
            count_nxt       = count_r - 1'b1;
            owner_nxt       = head_data_r;
            depth_nxt       = 8'd1;
            woken_valid_nxt = 1'b1;
            woken_task_nxt  = head_data_r;
            status_nxt      = ST_RELEASED;
          end else begin
            held_nxt   = 1'b0;
            owner_nxt  = 8'd0;
            depth_nxt  = 8'd0;
            status_nxt = ST_RELEASED;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= 1'b0;
      owner_r     <= 8'd0;
      depth_r     <= 8'd0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      owner_r     <= owner_nxt;
      depth_r     <= depth_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= (state_r == S_EXEC);
    end
  end

  // transaction capture and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_command;
      task_r <= in_task_id;
    end
    if (state_r == S_EXEC) begin
      status_r      <= status_nxt;
      woken_valid_r <= woken_valid_nxt;
      woken_task_r  <= woken_task_nxt;
      depth_out_r   <= depth_nxt;
    end
  end

  // waiter memory: head read on accept, tail write on a queued lock
  always_ff @(posedge clk) begin
    if (accept) begin
      head_data_r <= waiter_mem[head_r];
    end
    if (wr_en) begin
      waiter_mem[tail_r] <= task_r;
    end
  end

  assign busy            = (state_r == S_EXEC);
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_woken_valid = woken_valid_r;
  assign out_woken_task  = woken_task_r;
  assign out_depth_after = depth_out_r;

endmodule

// ----- rtl/rmfh_port_checker.sv -----
// rmfh_port_checker: port-level assertions for the recursive mutex unit
// depends on rmfh_pkg; bound to recursive_mutex_fifo_handoff_top below
module rmfh_port_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input rmfh_pkg::status_t out_status,
  input logic              out_woken_valid,
  input logic [7:0]        out_woken_task,
  input logic [7:0]        out_depth_after
);
  import rmfh_pkg::*;

  // an accepted transaction keeps the unit busy for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // each busy cycle ends in exactly one result and frees the input
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid && !busy)
    else $error("busy cycle not followed by a result");

  // result strobe lasts a single cycle
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // a handoff is only reported on a release and leaves depth one
  a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_woken_valid |-> out_status == ST_RELEASED && out_depth_after == 8'd1)
    else $error("handoff reported with wrong status or depth");

  // woken task reads zero when nobody was handed the lock
  a_woken_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_woken_valid |-> out_woken_task == 8'd0)
    else $error("woken task nonzero without handoff");

endmodule

bind recursive_mutex_fifo_handoff_top rmfh_port_checker u_rmfh_port_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_woken_valid (out_woken_valid),
  .out_woken_task  (out_woken_task),
  .out_depth_after (out_depth_after)
);
